// File: rtl/pn2d_pkg.sv
// ----------------------------------------------------------------------------
// pn2d_pkg
// Shared types, register indexes, permutation ROM and index wrap helper
// for the 2D gradient noise pipeline.
// ----------------------------------------------------------------------------
package pn2d_pkg;

   typedef struct packed {
      logic [15:0] seed_offset;
      logic [15:0] period_x;
      logic [15:0] period_y;
   } cfg_type;

   // low lattice index bits and sign of one axis
   typedef struct packed {
      logic [7:0] lo;
      logic       neg;
   } axis_type;

   // wrapped corner indices of one axis
   typedef struct packed {
      logic [7:0] i0;
      logic [7:0] i1;
   } idx_type;

   localparam logic [1:0] CSR_SEED_OFFSET = 2'd0;
   localparam logic [1:0] CSR_PERIOD_X    = 2'd1;
   localparam logic [1:0] CSR_PERIOD_Y    = 2'd2;

   // gradient selector bits of the hash
   localparam int GRAD_NEG_U = 0;
   localparam int GRAD_NEG_V = 1;
   localparam int GRAD_SWAP  = 2;

   // 0.507 as Q0.16
   localparam logic signed [16:0] SCALE_Q16 = 17'sd33227;

   localparam logic [7:0] PERM_ROM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
      8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
      8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
      8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
      8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
      8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
      8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
      8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
      8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
      8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
      8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
      8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
      8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
      8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
      8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
      8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
      8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
      8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
      8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
      8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
      8'd215,8'd61,8'd156,8'd180
   };

   // Corner indices i and i+1 of one axis. rem is |i| mod period; a negative
   // index takes a truncating remainder, so it lands in (-period, 0].
   function automatic idx_type wrap_pair(axis_type ax, logic [15:0] rem,
                                         logic [15:0] period);
      idx_type     r;
      logic [16:0] rem_p1;
      rem_p1 = {1'b0, rem} + 17'd1;
      if (period == 16'd0) begin
         r.i0 = ax.lo;
         r.i1 = ax.lo + 8'd1;
      end else if (!ax.neg) begin
         r.i0 = rem[7:0];
         r.i1 = (rem_p1 == {1'b0, period}) ? 8'd0 : rem_p1[7:0];
      end else begin
         r.i0 = 8'd0 - rem[7:0];
         r.i1 = (rem == 16'd0) ? (8'd1 - period[7:0]) : (8'd1 - rem[7:0]);
      end
      return r;
   endfunction

endpackage

// File: rtl/pn2d_split.sv
// ----------------------------------------------------------------------------
// pn2d_split
// Seed subtract and floor split of the point into lattice index and fraction.
// ----------------------------------------------------------------------------
module pn2d_split #(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic signed [31:0]        x_coord,
   input  logic signed [31:0]        y_coord,
   input  pn2d_pkg::cfg_type         cfg,
   output logic                      out_valid,
   input  logic                      out_ready,
   output logic [FRAC_BITS-1:0]      fx0,
   output logic [FRAC_BITS-1:0]      fy0,
   output pn2d_pkg::axis_type        axis_x,
   output pn2d_pkg::axis_type        axis_y,
   output logic [31-FRAC_BITS:0]     mag_x,
   output logic [31-FRAC_BITS:0]     mag_y
);

   localparam int F  = FRAC_BITS;
   localparam int IW = 33 - F;
   localparam int MW = 32 - F;

   logic [15+F:0]          seed_wide;
   logic [F-1:0]           seed_al;
   logic [32:0]            p_c [2];
   logic [IW-1:0]          i_c [2];
   logic [IW-1:0]          ineg_c [2];

   logic                   valid_ff;
   logic [F-1:0]           f_in [2];
   logic [F-1:0]           f_ff [2];
   pn2d_pkg::axis_type     ax_in [2];
   pn2d_pkg::axis_type     ax_ff [2];
   logic [MW-1:0]          mag_in [2];
   logic [MW-1:0]          mag_ff [2];

   always_comb begin
      seed_wide = {cfg.seed_offset, {F{1'b0}}};
      seed_al   = seed_wide[15+F:16];
      p_c[0]    = {x_coord[31], x_coord} - {{(33-F){1'b0}}, seed_al};
      p_c[1]    = {y_coord[31], y_coord} - {{(33-F){1'b0}}, seed_al};
      for (int l = 0; l < 2; l++) begin
         i_c[l]       = p_c[l][32:F];
         ineg_c[l]    = {IW{1'b0}} - i_c[l];
         f_in[l]      = p_c[l][F-1:0];
         ax_in[l].lo  = i_c[l][7:0];
         ax_in[l].neg = p_c[l][32];
         mag_in[l]    = p_c[l][32] ? ineg_c[l][MW-1:0] : i_c[l][MW-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         f_ff   <= f_in;
         ax_ff  <= ax_in;
         mag_ff <= mag_in;
      end
   end

   assign out_valid = valid_ff;
   assign fx0       = f_ff[0];
   assign fy0       = f_ff[1];
   assign axis_x    = ax_ff[0];
   assign axis_y    = ax_ff[1];
   assign mag_x     = mag_ff[0];
   assign mag_y     = mag_ff[1];

endmodule

// File: rtl/pn2d_rem.sv
// ----------------------------------------------------------------------------
// pn2d_rem
// Pipelined restoring remainder of |index| by the period, one bit per stage,
// both axes side by side; other fields ride along.
// ----------------------------------------------------------------------------
module pn2d_rem #(
   parameter int FRAC_BITS = 16,
   parameter int PAY_W     = 50
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [31-FRAC_BITS:0] mag_x,
   input  logic [31-FRAC_BITS:0] mag_y,
   input  logic [PAY_W-1:0]      pay,
   input  pn2d_pkg::cfg_type     cfg,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [15:0]           rem_x,
   output logic [15:0]           rem_y,
   output logic [PAY_W-1:0]      out_pay
);

   localparam int MW = 32 - FRAC_BITS;
   localparam int N  = MW;

   logic             valid_ff [N];
   logic [N:0]       adv;
   logic [MW-1:0]    magx_ff [N];
   logic [MW-1:0]    magy_ff [N];
   logic [15:0]      remx_ff [N];
   logic [15:0]      remy_ff [N];
   logic [PAY_W-1:0] pay_ff [N];
   logic [MW-1:0]    magx_in [N];
   logic [MW-1:0]    magy_in [N];
   logic [15:0]      remx_in [N];
   logic [15:0]      remy_in [N];
   logic [PAY_W-1:0] pay_in [N];

   function automatic logic [15:0] rem_step(logic [15:0] r, logic b, logic [15:0] p);
      logic [16:0] t;
      t = {r, b};
      if (t >= {1'b0, p}) begin
         t = t - {1'b0, p};
      end
      return t[15:0];
   endfunction

   always_comb begin
      adv[N] = out_ready;
      for (int k = N - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      magx_in[0] = mag_x;
      magy_in[0] = mag_y;
      pay_in[0]  = pay;
      remx_in[0] = rem_step(16'd0, mag_x[MW-1], cfg.period_x);
      remy_in[0] = rem_step(16'd0, mag_y[MW-1], cfg.period_y);
      for (int k = 1; k < N; k++) begin
         magx_in[k] = magx_ff[k-1];
         magy_in[k] = magy_ff[k-1];
         pay_in[k]  = pay_ff[k-1];
         remx_in[k] = rem_step(remx_ff[k-1], magx_ff[k-1][MW-1-k], cfg.period_x);
         remy_in[k] = rem_step(remy_ff[k-1], magy_ff[k-1][MW-1-k], cfg.period_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < N; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < N; k++) begin
         if (adv[k]) begin
            magx_ff[k] <= magx_in[k];
            magy_ff[k] <= magy_in[k];
            remx_ff[k] <= remx_in[k];
            remy_ff[k] <= remy_in[k];
            pay_ff[k]  <= pay_in[k];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign rem_x     = remx_ff[N-1];
   assign rem_y     = remy_ff[N-1];
   assign out_pay   = pay_ff[N-1];

`ifndef SYNTHESIS
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !valid_ff[0] && !valid_ff[N-1])
      else $error("rem pipeline valid survived reset");
   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !valid_ff[N-1] |-> in_ready)
      else $error("rem pipeline stalls with empty last stage");
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      in_valid && in_ready |=> valid_ff[0])
      else $error("accepted request lost at rem stage 0");
`endif

endmodule

// File: rtl/pn2d_corner.sv
// ----------------------------------------------------------------------------
// pn2d_corner
// Corner index wrap, two-level permutation hash and gradient pick, with the
// quintic fade of both fractions in parallel; five stages.
// ----------------------------------------------------------------------------
module pn2d_corner #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [FRAC_BITS-1:0]        fx0,
   input  logic [FRAC_BITS-1:0]        fy0,
   input  pn2d_pkg::axis_type          axis_x,
   input  pn2d_pkg::axis_type          axis_y,
   input  logic [15:0]                 rem_x,
   input  logic [15:0]                 rem_y,
   input  pn2d_pkg::cfg_type           cfg,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [FRAC_BITS+5:0] fade_s,
   output logic signed [FRAC_BITS+5:0] fade_t,
   output logic signed [FRAC_BITS+5:0] g00,
   output logic signed [FRAC_BITS+5:0] g01,
   output logic signed [FRAC_BITS+5:0] g10,
   output logic signed [FRAC_BITS+5:0] g11
);

   localparam int F  = FRAC_BITS;
   localparam int VW = F + 6;
   localparam int PW = 2 * VW;
   localparam int NS = 5;

   localparam logic signed [VW-1:0] ONE_FX     = VW'(1) << F;
   localparam logic signed [VW-1:0] TEN_FX     = VW'(10) << F;
   localparam logic signed [VW-1:0] FIFTEEN_FX = VW'(15) << F;
   localparam logic signed [VW-1:0] SIX        = VW'(6);
   localparam logic signed [PW-1:0] HALF_LSB   = PW'(1) << (F - 1);

   function automatic logic signed [VW-1:0] rnd(logic signed [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = (p + HALF_LSB) >>> F;
      return t[VW-1:0];
   endfunction

   function automatic logic signed [VW-1:0] tval(logic [F-1:0] f);
      return $signed({{(VW-F){1'b0}}, f});
   endfunction

   function automatic logic signed [VW-1:0] grad(logic [7:0] h,
                                                 logic signed [VW-1:0] gx,
                                                 logic signed [VW-1:0] gy);
      logic signed [VW-1:0] u;
      logic signed [VW-1:0] v;
      logic signed [VW-1:0] a;
      logic signed [VW-1:0] b;
      u = h[pn2d_pkg::GRAD_SWAP] ? gy : gx;
      v = h[pn2d_pkg::GRAD_SWAP] ? gx : gy;
      a = h[pn2d_pkg::GRAD_NEG_U] ? -u : u;
      b = h[pn2d_pkg::GRAD_NEG_V] ? -(v <<< 1) : (v <<< 1);
      return a + b;
   endfunction

   logic        valid_ff [NS];
   logic [NS:0] adv;

   // lane 0 is x, lane 1 is y
   logic [F-1:0]          f_in [2];
   logic [F-1:0]          s1_f_ff [2];
   logic [F-1:0]          s2_f_ff [2];
   logic [F-1:0]          s3_f_ff [2];
   logic signed [PW-1:0]  s1_m_in [2];
   logic signed [PW-1:0]  s2_m_in [2];
   logic signed [PW-1:0]  s3_m_in [2];
   logic signed [PW-1:0]  s4_m_in [2];
   logic signed [PW-1:0]  s1_m_ff [2];
   logic signed [PW-1:0]  s2_m_ff [2];
   logic signed [PW-1:0]  s3_m_ff [2];
   logic signed [PW-1:0]  s4_m_ff [2];
   logic signed [VW-1:0]  s5_fade_in [2];
   logic signed [VW-1:0]  s5_fade_ff [2];

   pn2d_pkg::idx_type     s1_idx_in [2];
   pn2d_pkg::idx_type     s1_idx_ff [2];
   pn2d_pkg::idx_type     s2_x_ff;
   logic [7:0]            s2_hy_in [2];
   logic [7:0]            s2_hy_ff [2];
   logic [7:0]            hsum [4];
   logic [7:0]            s3_h_in [4];
   logic [7:0]            s3_h_ff [4];
   logic signed [VW-1:0]  s4_g_in [4];
   logic signed [VW-1:0]  s4_g_ff [4];
   logic signed [VW-1:0]  s5_g_ff [4];
   logic signed [VW-1:0]  fx_a;
   logic signed [VW-1:0]  fx_b;
   logic signed [VW-1:0]  fy_a;
   logic signed [VW-1:0]  fy_b;
   logic signed [VW-1:0]  t0;

   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      f_in[0]      = fx0;
      f_in[1]      = fy0;
      s1_idx_in[0] = pn2d_pkg::wrap_pair(axis_x, rem_x, cfg.period_x);
      s1_idx_in[1] = pn2d_pkg::wrap_pair(axis_y, rem_y, cfg.period_y);
      for (int l = 0; l < 2; l++) begin
         t0            = tval(f_in[l]);
         s1_m_in[l]    = t0 * (SIX * t0 - FIFTEEN_FX);
         s2_m_in[l]    = tval(s1_f_ff[l]) * (rnd(s1_m_ff[l]) + TEN_FX);
         s3_m_in[l]    = tval(s2_f_ff[l]) * rnd(s2_m_ff[l]);
         s4_m_in[l]    = tval(s3_f_ff[l]) * rnd(s3_m_ff[l]);
         s5_fade_in[l] = rnd(s4_m_ff[l]);
      end
      s2_hy_in[0] = pn2d_pkg::PERM_ROM[s1_idx_ff[1].i0];
      s2_hy_in[1] = pn2d_pkg::PERM_ROM[s1_idx_ff[1].i1];
      hsum[0]     = s2_x_ff.i0 + s2_hy_ff[0];
      hsum[1]     = s2_x_ff.i0 + s2_hy_ff[1];
      hsum[2]     = s2_x_ff.i1 + s2_hy_ff[0];
      hsum[3]     = s2_x_ff.i1 + s2_hy_ff[1];
      for (int c = 0; c < 4; c++) begin
         s3_h_in[c] = pn2d_pkg::PERM_ROM[hsum[c]];
      end
      fx_a       = tval(s3_f_ff[0]);
      fx_b       = fx_a - ONE_FX;
      fy_a       = tval(s3_f_ff[1]);
      fy_b       = fy_a - ONE_FX;
      s4_g_in[0] = grad(s3_h_ff[0], fx_a, fy_a);
      s4_g_in[1] = grad(s3_h_ff[1], fx_a, fy_b);
      s4_g_in[2] = grad(s3_h_ff[2], fx_b, fy_a);
      s4_g_in[3] = grad(s3_h_ff[3], fx_b, fy_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         s1_f_ff   <= f_in;
         s1_m_ff   <= s1_m_in;
         s1_idx_ff <= s1_idx_in;
      end
      if (adv[1]) begin
         s2_f_ff  <= s1_f_ff;
         s2_m_ff  <= s2_m_in;
         s2_x_ff  <= s1_idx_ff[0];
         s2_hy_ff <= s2_hy_in;
      end
      if (adv[2]) begin
         s3_f_ff <= s2_f_ff;
         s3_m_ff <= s3_m_in;
         s3_h_ff <= s3_h_in;
      end
      if (adv[3]) begin
         s4_m_ff <= s4_m_in;
         s4_g_ff <= s4_g_in;
      end
      if (adv[4]) begin
         s5_fade_ff <= s5_fade_in;
         s5_g_ff    <= s4_g_ff;
      end
   end

   assign out_valid = valid_ff[NS-1];
   assign fade_s    = s5_fade_ff[0];
   assign fade_t    = s5_fade_ff[1];
   assign g00       = s5_g_ff[0];
   assign g01       = s5_g_ff[1];
   assign g10       = s5_g_ff[2];
   assign g11       = s5_g_ff[3];

endmodule

// File: rtl/pn2d_blend.sv
// ----------------------------------------------------------------------------
// pn2d_blend
// Bilinear blend of the corner gradients, 0.507 scale, round and saturate
// to Q2.14; six stages, the last one is the result register.
// ----------------------------------------------------------------------------
module pn2d_blend #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic signed [FRAC_BITS+5:0] fade_s,
   input  logic signed [FRAC_BITS+5:0] fade_t,
   input  logic signed [FRAC_BITS+5:0] g00,
   input  logic signed [FRAC_BITS+5:0] g01,
   input  logic signed [FRAC_BITS+5:0] g10,
   input  logic signed [FRAC_BITS+5:0] g11,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic signed [15:0]          noise_value
);

   localparam int F  = FRAC_BITS;
   localparam int VW = F + 6;
   localparam int PW = 2 * VW;
   localparam int QW = VW + 17;
   localparam int NS = 6;

   localparam logic signed [PW-1:0] HALF_LSB = PW'(1) << (F - 1);
   localparam logic signed [QW-1:0] Q_HALF   = QW'(1) << (F + 1);
   localparam logic signed [QW-1:0] SAT_HI   = QW'(32767);
   localparam logic signed [QW-1:0] SAT_LO   = -QW'(32768);

   function automatic logic signed [VW-1:0] rnd(logic signed [PW-1:0] p);
      logic signed [PW-1:0] t;
      t = (p + HALF_LSB) >>> F;
      return t[VW-1:0];
   endfunction

   logic        valid_ff [NS];
   logic [NS:0] adv;

   logic signed [PW-1:0] b1_p0_in, b1_p1_in, b1_p0_ff, b1_p1_ff;
   logic signed [VW-1:0] b1_g00_ff, b1_g10_ff, b1_s_ff;
   logic signed [VW-1:0] b2_n0_in, b2_n1_in, b2_n0_ff, b2_n1_ff, b2_s_ff;
   logic signed [PW-1:0] b3_p_in, b3_p_ff;
   logic signed [VW-1:0] b3_n0_ff;
   logic signed [VW-1:0] b4_n_in, b4_n_ff;
   logic signed [QW-1:0] b5_q_in, b5_q_ff;
   logic signed [QW-1:0] rq;
   logic signed [15:0]   b6_r_in, b6_r_ff;

   always_comb begin
      adv[NS] = out_ready;
      for (int k = NS - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   assign in_ready = adv[0];

   always_comb begin
      b1_p0_in = fade_t * (g01 - g00);
      b1_p1_in = fade_t * (g11 - g10);
      b2_n0_in = b1_g00_ff + rnd(b1_p0_ff);
      b2_n1_in = b1_g10_ff + rnd(b1_p1_ff);
      b3_p_in  = b2_s_ff * (b2_n1_ff - b2_n0_ff);
      b4_n_in  = b3_n0_ff + rnd(b3_p_ff);
      b5_q_in  = b4_n_ff * pn2d_pkg::SCALE_Q16;
      rq       = (b5_q_ff + Q_HALF) >>> (F + 2);
      if (rq > SAT_HI) begin
         b6_r_in = 16'sh7fff;
      end else if (rq < SAT_LO) begin
         b6_r_in = -16'sh8000;
      end else begin
         b6_r_in = rq[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= in_valid;
         end
         for (int k = 1; k < NS; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         b1_p0_ff  <= b1_p0_in;
         b1_p1_ff  <= b1_p1_in;
         b1_g00_ff <= g00;
         b1_g10_ff <= g10;
         b1_s_ff   <= fade_s;
      end
      if (adv[1]) begin
         b2_n0_ff <= b2_n0_in;
         b2_n1_ff <= b2_n1_in;
         b2_s_ff  <= b1_s_ff;
      end
      if (adv[2]) begin
         b3_p_ff  <= b3_p_in;
         b3_n0_ff <= b2_n0_ff;
      end
      if (adv[3]) begin
         b4_n_ff <= b4_n_in;
      end
      if (adv[4]) begin
         b5_q_ff <= b5_q_in;
      end
      if (adv[5]) begin
         b6_r_ff <= b6_r_in;
      end
   end

   assign out_valid   = valid_ff[NS-1];
   assign noise_value = b6_r_ff;

endmodule

// File: rtl/perlin_noise_2d.sv
// ----------------------------------------------------------------------------
// perlin_noise_2d
// 2D improved gradient noise, one signed fixed-point point in, one Q2.14
// noise sample out.
// ----------------------------------------------------------------------------
// Fully pipelined: one request per clock unless a held result has backed the
// pipe up. The period remainder retires one index bit per stage over
// 32 - FRAC_BITS stages; then come five stages of hash and fade and six
// of blend and scale. Every stage holds its own valid bit and only stalls
// when the stage after it is full, so bubbles close up and a waiting result
// blocks new requests only once every stage ahead of it is full.
// Registers (csr_index): 0 seed_offset, Q0.16 fraction taken off both
// coordinates; 1 period_x and 2 period_y, lattice periods, zero means no
// wrap. Change them only while the pipeline is empty.
module perlin_noise_2d #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_noise_value,
   // register writes
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_write_data
);

   localparam int F     = FRAC_BITS;
   localparam int MW    = 32 - F;
   localparam int AXW   = $bits(pn2d_pkg::axis_type);
   localparam int PAY_W = 2 * F + 2 * AXW;
   localparam int VW    = F + 6;

   pn2d_pkg::cfg_type cfg_ff, cfg_in;

   // split -> remainder
   logic               sp_valid, sp_ready;
   logic [F-1:0]       sp_fx0, sp_fy0;
   pn2d_pkg::axis_type sp_ax, sp_ay;
   logic [MW-1:0]      sp_mag_x, sp_mag_y;
   logic [PAY_W-1:0]   sp_pay;

   // remainder -> corner
   logic               rm_valid, rm_ready;
   logic [15:0]        rm_rem_x, rm_rem_y;
   logic [PAY_W-1:0]   rm_pay;
   logic [F-1:0]       rm_fx0, rm_fy0;
   pn2d_pkg::axis_type rm_ax, rm_ay;

   // corner -> blend
   logic                 cn_valid, cn_ready;
   logic signed [VW-1:0] cn_s, cn_t, cn_g00, cn_g01, cn_g10, cn_g11;

   // register file; writes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            pn2d_pkg::CSR_SEED_OFFSET: cfg_in.seed_offset = csr_write_data;
            pn2d_pkg::CSR_PERIOD_X:    cfg_in.period_x    = csr_write_data;
            pn2d_pkg::CSR_PERIOD_Y:    cfg_in.period_y    = csr_write_data;
            default:                   cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // seed subtract, floor and fraction
   pn2d_split #(.FRAC_BITS(F)) u_split (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .x_coord   (req_x_coord),
      .y_coord   (req_y_coord),
      .cfg       (cfg_ff),
      .out_valid (sp_valid),
      .out_ready (sp_ready),
      .fx0       (sp_fx0),
      .fy0       (sp_fy0),
      .axis_x    (sp_ax),
      .axis_y    (sp_ay),
      .mag_x     (sp_mag_x),
      .mag_y     (sp_mag_y)
   );

   assign sp_pay = {sp_fx0, sp_fy0, sp_ax, sp_ay};

   // |index| mod period, both axes
   pn2d_rem #(.FRAC_BITS(F), .PAY_W(PAY_W)) u_rem (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sp_valid),
      .in_ready  (sp_ready),
      .mag_x     (sp_mag_x),
      .mag_y     (sp_mag_y),
      .pay       (sp_pay),
      .cfg       (cfg_ff),
      .out_valid (rm_valid),
      .out_ready (rm_ready),
      .rem_x     (rm_rem_x),
      .rem_y     (rm_rem_y),
      .out_pay   (rm_pay)
   );

   assign rm_fx0 = rm_pay[PAY_W-1 -: F];
   assign rm_fy0 = rm_pay[PAY_W-1-F -: F];
   assign rm_ax  = pn2d_pkg::axis_type'(rm_pay[2*AXW-1:AXW]);
   assign rm_ay  = pn2d_pkg::axis_type'(rm_pay[AXW-1:0]);

   // index wrap, hash, gradients, fade
   pn2d_corner #(.FRAC_BITS(F)) u_corner (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rm_valid),
      .in_ready  (rm_ready),
      .fx0       (rm_fx0),
      .fy0       (rm_fy0),
      .axis_x    (rm_ax),
      .axis_y    (rm_ay),
      .rem_x     (rm_rem_x),
      .rem_y     (rm_rem_y),
      .cfg       (cfg_ff),
      .out_valid (cn_valid),
      .out_ready (cn_ready),
      .fade_s    (cn_s),
      .fade_t    (cn_t),
      .g00       (cn_g00),
      .g01       (cn_g01),
      .g10       (cn_g10),
      .g11       (cn_g11)
   );

   // lerps, scale, saturate; holds the result register
   pn2d_blend #(.FRAC_BITS(F)) u_blend (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (cn_valid),
      .in_ready    (cn_ready),
      .fade_s      (cn_s),
      .fade_t      (cn_t),
      .g00         (cn_g00),
      .g01         (cn_g01),
      .g10         (cn_g10),
      .g11         (cn_g11),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .noise_value (rsp_noise_value)
   );

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 2D gradient noise pipeline: a directed table,
// fixed wrap points, then random points under several idle/stall phases and
// register settings, all compared against an in-bench fixed-point noise predictor.
// ----------------------------------------------------------------------------
module tb_top;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS  = 16;
   localparam int LATENCY    = 44 - FRAC_BITS;
   localparam longint ONE_FX = longint'(1) << FRAC_BITS;
   localparam int CYCLE_LIMIT = 900000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [31:0] req_x_coord = '0;
   logic signed [31:0] req_y_coord = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_noise_value;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = pn2d_pkg::CSR_SEED_OFFSET;
   logic [15:0]        csr_write_data = '0;

   perlin_noise_2d #(.FRAC_BITS(FRAC_BITS)) u_top (.*);

   always #4 clock = ~clock;

   // local copy of the register file
   logic [15:0] seed_q, per_x_q, per_y_q;

   logic signed [15:0] noise_expect_q[$];
   int  mismatches = 0;
   int  cycles = 0;
   int  send_idle_pct = 0;   // sender idle chance, percent
   int  recv_stall_pct = 0;  // receiver stall chance, percent
   bit  hold_off = 1'b0;     // long receiver hold-off
   int  hold_cycles = 0;

   // directed table: x, y, with a typed-in expectation where obvious
   typedef struct {
      logic signed [31:0] x;
      logic signed [31:0] y;
      bit                 known;
      logic signed [15:0] value;
   } point_row_type;

   // ---------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------
   // floor(v / 2^sh)
   function automatic longint fl_shift(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic longint fx_mul(longint a, longint b);
      return fl_shift(a * b + (ONE_FX >>> 1), FRAC_BITS);
   endfunction

   function automatic longint fade(longint t);
      longint a, b, c, d;
      a = 6 * t - 15 * ONE_FX;
      b = fx_mul(t, a) + 10 * ONE_FX;
      c = fx_mul(t, b);
      d = fx_mul(t, c);
      return fx_mul(t, d);
   endfunction

   function automatic longint grad_dot(logic [7:0] hash, longint fx, longint fy);
      longint u, v, a, b;
      u = hash[pn2d_pkg::GRAD_SWAP] ? fy : fx;
      v = hash[pn2d_pkg::GRAD_SWAP] ? fx : fy;
      a = hash[pn2d_pkg::GRAD_NEG_U] ? -u : u;
      b = hash[pn2d_pkg::GRAD_NEG_V] ? -2 * v : 2 * v;
      return a + b;
   endfunction

   // truncating remainder (SV % truncates), then two's complement to 8 bits
   function automatic logic [7:0] lattice_wrap(longint i, logic [15:0] period);
      longint r;
      r = (period != 0) ? i % longint'(period) : i;
      return r[7:0];
   endfunction

   function automatic logic [7:0] corner_hash(logic [7:0] xi, logic [7:0] yi);
      logic [7:0] s;
      s = xi + pn2d_pkg::PERM_ROM[yi];
      return pn2d_pkg::PERM_ROM[s];
   endfunction

   function automatic logic signed [15:0] noise_at(logic signed [31:0] x,
                                                   logic signed [31:0] y);
      longint seed, px, py, ix, iy, fx0, fy0, fx1, fy1, s, t;
      longint g00, g01, g10, g11, n0, n1, n, r;
      logic [7:0] x0, x1, y0, y1;
      seed = (longint'(seed_q) << FRAC_BITS) >>> 16;
      px = longint'(x) - seed;
      py = longint'(y) - seed;
      ix = px >>> FRAC_BITS;
      iy = py >>> FRAC_BITS;
      fx0 = px & (ONE_FX - 1);
      fy0 = py & (ONE_FX - 1);
      fx1 = fx0 - ONE_FX;
      fy1 = fy0 - ONE_FX;
      x0 = lattice_wrap(ix, per_x_q);
      x1 = lattice_wrap(ix + 1, per_x_q);
      y0 = lattice_wrap(iy, per_y_q);
      y1 = lattice_wrap(iy + 1, per_y_q);
      s = fade(fx0);
      t = fade(fy0);
      g00 = grad_dot(corner_hash(x0, y0), fx0, fy0);
      g01 = grad_dot(corner_hash(x0, y1), fx0, fy1);
      g10 = grad_dot(corner_hash(x1, y0), fx1, fy0);
      g11 = grad_dot(corner_hash(x1, y1), fx1, fy1);
      n0 = g00 + fx_mul(t, g01 - g00);
      n1 = g10 + fx_mul(t, g11 - g10);
      n  = n0 + fx_mul(s, n1 - n0);
      r  = fl_shift(n * 33227 + (longint'(1) << (FRAC_BITS + 1)), FRAC_BITS + 2);
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   // ---------------------------------------------------------------------
   // driving helpers (falling edge)
   // ---------------------------------------------------------------------
   task automatic csr_write(logic [1:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      case (idx)
         pn2d_pkg::CSR_SEED_OFFSET: seed_q  = data;
         pn2d_pkg::CSR_PERIOD_X:    per_x_q = data;
         default:                   per_y_q = data;
      endcase
   endtask

   task automatic apply_config(logic [15:0] sd, logic [15:0] pxv, logic [15:0] pyv);
      csr_write(pn2d_pkg::CSR_SEED_OFFSET, sd);
      csr_write(pn2d_pkg::CSR_PERIOD_X, pxv);
      csr_write(pn2d_pkg::CSR_PERIOD_Y, pyv);
   endtask

   // one request; sender idles at random before it, then holds until taken.
   // Valid is dropped by the idle loop or by drain, never twice in a step.
   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_x_coord <= x;
      req_y_coord <= y;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      noise_expect_q.push_back(noise_at(x, y));
      @(negedge clock);
   endtask

   // drain: stop offering, every expectation met, then let the pipe settle
   task automatic drain();
      req_valid <= 1'b0;
      wait (noise_expect_q.size() == 0);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(3))
         0:       return $urandom;                            // full range
         1:       return $signed($urandom_range(0, 32'h000A_0000))
                         - 32'sh0005_0000;                    // near origin
         2:       return {$urandom_range(0, 1) ? 16'h7FFF : 16'h8000,
                          16'($urandom)};                     // extremes
         default: return {16'($urandom_range(0, 600)) - 16'd300, 16'($urandom)};
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (hold_off) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         if (hold_cycles == 1) hold_off <= 1'b0;
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (noise_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response noise=%0d", rsp_noise_value);
         end else begin
            automatic logic signed [15:0] want = noise_expect_q.pop_front();
            if (rsp_noise_value !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("noise mismatch: expected %0d got %0d",
                           want, rsp_noise_value);
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // stimulus
   // ---------------------------------------------------------------------
   initial begin
      point_row_type rows[$];
      static logic [15:0] cfg_seed[6] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1234,
                                          16'h0000, 16'h0001};
      static logic [15:0] cfg_px[6]   = '{16'd0, 16'd1, 16'd256, 16'hFFFF, 16'd7, 16'd3};
      static logic [15:0] cfg_py[6]   = '{16'd0, 16'd1, 16'd5, 16'hFFFF, 16'd300, 16'd0};
      static int phase_send[4] = '{0, 84, 0, 29};
      static int phase_recv[4] = '{0, 0, 84, 29};

      seed_q = '0; per_x_q = '0; per_y_q = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (LATENCY) @(negedge clock);

      // directed: on lattice points both fades and the near corner's dot are zero
      rows.push_back('{32'sh0000_0000, 32'sh0000_0000, 1'b1, 16'sd0});
      rows.push_back('{32'sh0005_0000, 32'shFFFD_0000, 1'b1, 16'sd0});
      rows.push_back('{32'sh7FFF_0000, 32'sh8000_0000, 1'b1, 16'sd0});
      rows.push_back('{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 16'sd0});
      rows.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0, 16'sd0});
      rows.push_back('{32'sh8000_0001, 32'sh8000_0001, 1'b0, 16'sd0});
      rows.push_back('{32'sh0000_8000, 32'sh0000_8000, 1'b0, 16'sd0});
      rows.push_back('{32'shFFFF_8000, 32'shFFFF_8000, 1'b0, 16'sd0});
      rows.push_back('{32'shFFFF_FFFF, 32'sh0000_0001, 1'b0, 16'sd0});
      rows.push_back('{32'sh0001_2345, 32'shFFFE_DCBA, 1'b0, 16'sd0});
      rows.push_back('{32'shFFFA_4000, 32'sh0000_C000, 1'b0, 16'sd0});
      rows.push_back('{32'sh5555_5555, 32'shAAAA_AAAA, 1'b0, 16'sd0});
      foreach (rows[i]) begin
         send_point(rows[i].x, rows[i].y);
         if (rows[i].known && noise_at(rows[i].x, rows[i].y) !== rows[i].value) begin
            mismatches++;
            $display("table row %0d: expected %0d", i, rows[i].value);
         end
      end
      drain();

      // periodic wrap with negative cells, period of one, seed extremes
      for (int c = 0; c < 6; c++) begin
         apply_config(cfg_seed[c], cfg_px[c], cfg_py[c]);
         send_point(32'shFFF0_4000, 32'sh0010_C000);
         send_point(32'shFFFF_0000, 32'shFFFE_8000);
         drain();
      end

      // random: several register settings, each through all idling phases
      for (int c = 0; c < 6; c++) begin
         if (c < 5) apply_config(16'($urandom), 16'($urandom_range(0, 3) == 0 ? 0 :
                                 $urandom_range(0, 1) ? $urandom_range(1, 20) : $urandom),
                                 16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300)));
         else apply_config(cfg_seed[c - 4], cfg_px[c - 4], cfg_py[c - 4]);
         for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_send[p];
            recv_stall_pct = phase_recv[p];
            if (c == 0 && p == 0) begin
               // block the output long enough to back the pipe up
               hold_off    = 1'b1;
               hold_cycles = 4 * LATENCY + 40;
            end
            repeat (66) send_point(rand_coord(), rand_coord());
         end
         send_idle_pct = 0;
         recv_stall_pct = 0;
         drain();
      end

      if (mismatches == 0 && noise_expect_q.size() == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
